/* hw/rtl/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// shared types, codes and sizes of the tftp transfer engine
// ----------------------------------------------------------------------------
package tte_pkg;

    localparam int BLOCK_SIZE = 512;
    localparam int RX_CAP     = BLOCK_SIZE + 16;
    localparam int RES_MAX    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int FUNC_W = 2;
    localparam int OPC_W  = 8;
    localparam int BLK_W  = 16;
    localparam int LEN_W  = 10;
    localparam int ACT_W  = 4;
    localparam int ATT_W  = 4;
    localparam int IDX_W  = 1;
    localparam int CFG_W  = 4;

    localparam logic [LEN_W-1:0] BLK_SZ     = LEN_W'(BLOCK_SIZE);
    localparam logic [LEN_W-1:0] RX_MAX     = LEN_W'(RX_CAP);
    localparam logic [LEN_W-1:0] HDR_LEN    = LEN_W'(4);
    localparam logic [ATT_W-1:0] ATT_RESET  = ATT_W'(5);

    typedef enum logic [FUNC_W-1:0] {
        FN_START   = 2'd0,
        FN_RX      = 2'd1,
        FN_TIMEOUT = 2'd2,
        FN_LOCAL   = 2'd3
    } func_t;

    typedef enum logic [OPC_W-1:0] {
        OPC_DATA  = 8'd3,
        OPC_ACK   = 8'd4,
        OPC_ERROR = 8'd5
    } opcode_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 4'd0,
        ACT_REQ     = 4'd1,
        ACT_ACK     = 4'd2,
        ACT_DELIVER = 4'd3,
        ACT_DATA    = 4'd4,
        ACT_FETCH   = 4'd5,
        ACT_DONE    = 4'd6,
        ACT_SERR    = 4'd7,
        ACT_TFAIL   = 4'd8
    } action_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DIRECTION    = 1'd0,
        REG_MAX_ATTEMPTS = 1'd1
    } reg_idx_t;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_REQ_GET  = 6'b000010,
        PH_REQ_PUT  = 6'b000100,
        PH_RECV     = 6'b001000,
        PH_FETCH    = 6'b010000,
        PH_WAIT_ACK = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [BLK_W-1:0]   expected_block;
        logic [ATT_W-1:0]   attempt_count;
        logic [LEN_W-1:0]   pending_length;
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [OPC_W-1:0]   rx_opcode;
        logic [BLK_W-1:0]   rx_block;
        logic [LEN_W-1:0]   rx_length;
        logic [LEN_W-1:0]   local_length;
    } event_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [BLK_W-1:0]   block_number;
        logic [LEN_W-1:0]   payload_length;
        logic [BLK_W-1:0]   error_code;
        logic               last;
    } result_t;

    typedef struct packed {
        logic               direction;
        logic [ATT_W-1:0]   max_attempts;
    } config_t;

endpackage

/* hw/rtl/tte_if.sv */
// ----------------------------------------------------------------------------
// tte_if
// valid/ready channels of the tftp transfer engine
// ----------------------------------------------------------------------------
interface tte_evt_if;
    import tte_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [OPC_W-1:0]   rx_opcode;
    logic [BLK_W-1:0]   rx_block;
    logic [LEN_W-1:0]   rx_length;
    logic [LEN_W-1:0]   local_length;

    modport source (output valid, func, rx_opcode, rx_block, rx_length, local_length,
                    input ready);
    modport sink   (input valid, func, rx_opcode, rx_block, rx_length, local_length,
                    output ready);
endinterface

interface tte_res_if;
    import tte_pkg::*;

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [BLK_W-1:0]   block_number;
    logic [LEN_W-1:0]   payload_length;
    logic [BLK_W-1:0]   error_code;
    logic               last;

    modport source (output valid, action, block_number, payload_length, error_code, last,
                    input ready);
    modport sink   (input valid, action, block_number, payload_length, error_code, last,
                    output ready);
endinterface

interface tte_cfg_if;
    import tte_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [CFG_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/tte_step.sv */
// ----------------------------------------------------------------------------
// tte_step
// next state and up to three actions for one registered event
// ----------------------------------------------------------------------------
module tte_step (
    input  tte_pkg::state_t                     st,
    input  tte_pkg::event_t                     ev,
    input  tte_pkg::config_t                    cfg,
    output tte_pkg::state_t                     st_next,
    output tte_pkg::result_t [tte_pkg::RES_MAX-1:0] res,
    output logic [1:0]                          res_cnt
);
    import tte_pkg::*;

    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W-1:0] llen;
    logic             runt;
    logic             can_retry;
    logic             recv_go;
    logic [1:0]       k;

    assign rlen      = (ev.rx_length > RX_MAX) ? RX_MAX : ev.rx_length;
    assign dlen      = rlen - HDR_LEN;
    assign llen      = (ev.local_length > BLK_SZ) ? BLK_SZ : ev.local_length;
    assign runt      = (rlen < HDR_LEN);
    assign can_retry = (st.attempt_count < cfg.max_attempts);

    always_comb
    begin
        st_next = st;
        res     = '0;
        k       = 2'd0;
        recv_go = 1'b0;

        case (ev.func)
            FN_START:
            begin
                st_next.phase          = cfg.direction ? PH_REQ_PUT : PH_REQ_GET;
                st_next.expected_block = BLK_W'(1);
                st_next.attempt_count  = ATT_W'(1);
                st_next.pending_length = '0;
                res[0].action          = ACT_REQ;
                k                      = 2'd1;
            end
            FN_TIMEOUT:
            begin
                if (st.phase == PH_REQ_GET || st.phase == PH_REQ_PUT ||
                    st.phase == PH_WAIT_ACK)
                begin
                    if (can_retry)
                    begin
                        st_next.attempt_count = st.attempt_count + ATT_W'(1);
                        if (st.phase == PH_WAIT_ACK)
                        begin
                            res[0].action         = ACT_DATA;
                            res[0].block_number   = st.expected_block;
                            res[0].payload_length = st.pending_length;
                        end
                        else
                        begin
                            res[0].action = ACT_REQ;
                        end
                    end
                    else
                    begin
                        st_next.phase = PH_IDLE;
                        res[0].action = ACT_TFAIL;
                    end
                    k = 2'd1;
                end
                else if (st.phase == PH_RECV)
                begin
                    st_next.phase = PH_IDLE;
                    res[0].action = ACT_TFAIL;
                    k             = 2'd1;
                end
            end
            FN_LOCAL:
            begin
                if (st.phase == PH_FETCH)
                begin
                    st_next.pending_length = llen;
                    st_next.attempt_count  = ATT_W'(1);
                    st_next.phase          = PH_WAIT_ACK;
                    res[0].action          = ACT_DATA;
                    res[0].block_number    = st.expected_block;
                    res[0].payload_length  = llen;
                    k                      = 2'd1;
                end
            end
            default:
            begin
                if (st.phase == PH_REQ_GET || st.phase == PH_REQ_PUT)
                begin
                    if (runt)
                    begin
                        st_next.phase = PH_IDLE;
                        res[0].action = ACT_TFAIL;
                        k             = 2'd1;
                    end
                    else if (ev.rx_opcode == OPC_ERROR)
                    begin
                        st_next.phase     = PH_IDLE;
                        res[0].action     = ACT_SERR;
                        res[0].error_code = ev.rx_block;
                        k                 = 2'd1;
                    end
                    else if (st.phase == PH_REQ_PUT)
                    begin
                        if (ev.rx_opcode == OPC_ACK && ev.rx_block == '0)
                        begin
                            st_next.expected_block = BLK_W'(1);
                            st_next.phase          = PH_FETCH;
                            res[0].action          = ACT_FETCH;
                            res[0].block_number    = BLK_W'(1);
                            k                      = 2'd1;
                        end
                    end
                    else
                    begin
                        st_next.phase = PH_RECV;
                        recv_go       = 1'b1;
                    end
                end
                else if (st.phase == PH_RECV)
                begin
                    recv_go = 1'b1;
                end
                else if (st.phase == PH_WAIT_ACK)
                begin
                    if (!runt && ev.rx_opcode == OPC_ACK &&
                        ev.rx_block == st.expected_block)
                    begin
                        if (st.pending_length < BLK_SZ)
                        begin
                            st_next.phase = PH_IDLE;
                            res[0].action = ACT_DONE;
                        end
                        else
                        begin
                            st_next.expected_block = st.expected_block + BLK_W'(1);
                            st_next.phase          = PH_FETCH;
                            res[0].action          = ACT_FETCH;
                            res[0].block_number    = st.expected_block + BLK_W'(1);
                        end
                    end
                    else if (can_retry)
                    begin
                        st_next.attempt_count = st.attempt_count + ATT_W'(1);
                        res[0].action         = ACT_DATA;
                        res[0].block_number   = st.expected_block;
                        res[0].payload_length = st.pending_length;
                    end
                    else
                    begin
                        st_next.phase = PH_IDLE;
                        res[0].action = ACT_TFAIL;
                    end
                    k = 2'd1;
                end

                if (recv_go && !runt && ev.rx_opcode == OPC_DATA &&
                    ev.rx_block == st.expected_block)
                begin
                    if (dlen != '0)
                    begin
                        res[k].action         = ACT_DELIVER;
                        res[k].block_number   = ev.rx_block;
                        res[k].payload_length = dlen;
                        k                     = k + 2'd1;
                    end
                    res[k].action       = ACT_ACK;
                    res[k].block_number = ev.rx_block;
                    k                   = k + 2'd1;
                    if (dlen < BLK_SZ)
                    begin
                        st_next.phase = PH_IDLE;
                        res[k].action = ACT_DONE;
                        k             = k + 2'd1;
                    end
                    else
                    begin
                        st_next.expected_block = st.expected_block + BLK_W'(1);
                    end
                end
            end
        endcase

        for (int i = 0; i < RES_MAX; i++)
        begin
            res[i].last = (k != 2'd0) && (2'(i) == k - 2'd1);
        end
    end

    assign res_cnt = k;

endmodule

/* hw/rtl/tte_out_fifo.sv */
// ----------------------------------------------------------------------------
// tte_out_fifo
// result queue: up to three words in a cycle, one out when rslt is ready
// ----------------------------------------------------------------------------
module tte_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tte_pkg::result_t [tte_pkg::RES_MAX-1:0] wr_data,
    input  logic [1:0]                          wr_cnt,
    tte_res_if.source                           rslt,
    output logic [tte_pkg::FIFO_CW-1:0]         count
);
    import tte_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;
    result_t              head;

    assign head = mem_reg[rd_ptr_reg];
    assign pop  = rslt.valid && rslt.ready;

    assign rslt.valid          = (count_reg != '0);
    assign rslt.action         = head.action;
    assign rslt.block_number   = head.block_number;
    assign rslt.payload_length = head.payload_length;
    assign rslt.error_code     = head.error_code;
    assign rslt.last           = head.last;
    assign count               = count_reg;

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(wr_cnt) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (2'(i) < wr_cnt)
            begin
                mem_reg[FIFO_AW'(wr_ptr_reg + FIFO_AW'(i))] <= wr_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/tftp_transfer_engine.sv */
// ----------------------------------------------------------------------------
// tftp_transfer_engine
// header-level tftp client sequencer for one get or put transfer
//
//   channel  role    word
//   evt      sink    event: func, rx_opcode, rx_block, rx_length, local_length
//   rslt     source  action, block_number, payload_length, error_code, last
//   cfg      sink    register index and data, always ready
//
// an event is registered on accept and processed in the next cycle, which
// writes its zero to three actions into an eight-word result queue
// evt.ready is high while the queue has room for a full event: one event
// per cycle as long as rslt keeps up, one action per cycle on rslt
// reset returns to idle with direction get and five attempts
// ----------------------------------------------------------------------------
module tftp_transfer_engine (
    input  logic     clk,
    input  logic     rst_n,
    tte_evt_if.sink  evt,
    tte_res_if.source rslt,
    tte_cfg_if.sink  cfg
);
    import tte_pkg::*;

    config_t                  cfg_reg, cfg_next;
    state_t                   st_reg, st_next;
    logic                     stg_valid_reg;
    event_t                   stg_evt_reg;
    result_t [RES_MAX-1:0]    step_res;
    logic [1:0]               step_cnt;
    logic [1:0]               wr_cnt;
    logic [FIFO_CW-1:0]       fifo_count;
    logic [FIFO_CW:0]         committed;
    logic                     evt_take;

    assign committed = {1'b0, fifo_count} + (stg_valid_reg ? (FIFO_CW+1)'(RES_MAX) : '0);
    assign evt.ready = (committed <= (FIFO_CW+1)'(FIFO_DEPTH - RES_MAX));
    assign evt_take  = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;
    assign wr_cnt    = stg_valid_reg ? step_cnt : 2'd0;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_DIRECTION:    cfg_next.direction    = cfg.data[0];
                REG_MAX_ATTEMPTS: cfg_next.max_attempts = cfg.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    tte_step u_step (
        .st      (st_reg),
        .ev      (stg_evt_reg),
        .cfg     (cfg_reg),
        .st_next (st_next),
        .res     (step_res),
        .res_cnt (step_cnt)
    );

    tte_out_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (step_res),
        .wr_cnt  (wr_cnt),
        .rslt    (rslt),
        .count   (fifo_count)
    );

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            stg_evt_reg.func         <= evt.func;
            stg_evt_reg.rx_opcode    <= evt.rx_opcode;
            stg_evt_reg.rx_block     <= evt.rx_block;
            stg_evt_reg.rx_length    <= evt.rx_length;
            stg_evt_reg.local_length <= evt.local_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction     <= 1'b0;
            cfg_reg.max_attempts  <= ATT_RESET;
            st_reg.phase          <= PH_IDLE;
            st_reg.expected_block <= BLK_W'(1);
            st_reg.attempt_count  <= '0;
            st_reg.pending_length <= '0;
            stg_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            stg_valid_reg <= evt_take;
            if (stg_valid_reg)
            begin
                st_reg <= st_next;
            end
        end
    end

endmodule

/* tb/tftp_transfer_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tftp_transfer_engine_tb
// self-checking bench for the tftp transfer engine: a short table of get and
// put sequences, then random transfers under several register settings and
// idle patterns, action words checked against a table row or an engine model
// ----------------------------------------------------------------------------
module tftp_transfer_engine_tb;
    import tte_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_SEGMENTS = 6;
    localparam int SEG_ACTIVE    = 14;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic               reg_write;
        reg_idx_t           reg_sel;
        logic [CFG_W-1:0]   reg_val;
        event_t             ev;
        logic               typed;
        result_t            want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    tte_evt_if evt_bus ();
    tte_res_if act_bus ();
    tte_cfg_if cfg_bus ();

    tftp_transfer_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_bus),
        .rslt  (act_bus),
        .cfg   (cfg_bus)
    );

    phase_t             tr_phase;
    logic [BLK_W-1:0]   tr_block;
    logic [ATT_W-1:0]   tr_tries;
    logic [LEN_W-1:0]   tr_len;
    logic               reg_dir;
    logic [ATT_W-1:0]   reg_tries;

    result_t step_actions [$];
    result_t actions_due [$];

    int snd_idle    = 0;
    int rcv_idle    = 0;
    int err_count   = 0;
    int n_events    = 0;
    int n_active    = 0;
    int n_checked   = 0;
    int n_writes    = 0;
    int cycle_count = 0;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic result_t act_word(action_t a, logic [BLK_W-1:0] b,
                                         logic [LEN_W-1:0] l, logic [BLK_W-1:0] e);
        return {a, b, l, e, 1'b0};
    endfunction

    function automatic void give_up();
        tr_phase = PH_IDLE;
        step_actions.push_back(act_word(ACT_TFAIL, '0, '0, '0));
    endfunction

    function automatic void resend_block();
        if (tr_tries < reg_tries)
        begin
            tr_tries = tr_tries + ATT_W'(1);
            step_actions.push_back(act_word(ACT_DATA, tr_block, tr_len, '0));
        end
        else
            give_up();
    endfunction

    function automatic void advance_transfer(event_t ev);
        logic [LEN_W-1:0] rlen;
        logic [LEN_W-1:0] dlen;
        result_t          tail;
        step_actions.delete();
        rlen = (ev.rx_length > RX_MAX) ? RX_MAX : ev.rx_length;
        case (ev.func)
            FN_START:
            begin
                tr_phase = reg_dir ? PH_REQ_PUT : PH_REQ_GET;
                tr_block = BLK_W'(1);
                tr_tries = ATT_W'(1);
                tr_len   = '0;
                step_actions.push_back(act_word(ACT_REQ, '0, '0, '0));
            end
            FN_TIMEOUT:
            begin
                if (tr_phase == PH_REQ_GET || tr_phase == PH_REQ_PUT)
                begin
                    if (tr_tries < reg_tries)
                    begin
                        tr_tries = tr_tries + ATT_W'(1);
                        step_actions.push_back(act_word(ACT_REQ, '0, '0, '0));
                    end
                    else
                        give_up();
                end
                else if (tr_phase == PH_RECV)
                    give_up();
                else if (tr_phase == PH_WAIT_ACK)
                    resend_block();
            end
            FN_LOCAL:
            begin
                if (tr_phase == PH_FETCH)
                begin
                    tr_len   = (ev.local_length > BLK_SZ) ? BLK_SZ : ev.local_length;
                    tr_tries = ATT_W'(1);
                    tr_phase = PH_WAIT_ACK;
                    step_actions.push_back(act_word(ACT_DATA, tr_block, tr_len, '0));
                end
            end
            default:
            begin
                if (tr_phase == PH_REQ_GET || tr_phase == PH_REQ_PUT)
                begin
                    if (rlen < HDR_LEN)
                        give_up();
                    else if (ev.rx_opcode == OPC_ERROR)
                    begin
                        tr_phase = PH_IDLE;
                        step_actions.push_back(act_word(ACT_SERR, '0, '0, ev.rx_block));
                    end
                    else if (tr_phase == PH_REQ_PUT)
                    begin
                        if (ev.rx_opcode == OPC_ACK && ev.rx_block == '0)
                        begin
                            tr_block = BLK_W'(1);
                            tr_phase = PH_FETCH;
                            step_actions.push_back(act_word(ACT_FETCH, tr_block, '0, '0));
                        end
                    end
                    else
                        tr_phase = PH_RECV; // first reply is taken as a data word below
                end
                if (tr_phase == PH_RECV)
                begin
                    if (rlen >= HDR_LEN && ev.rx_opcode == OPC_DATA && ev.rx_block == tr_block)
                    begin
                        dlen = rlen - HDR_LEN;
                        if (dlen != '0)
                            step_actions.push_back(act_word(ACT_DELIVER, tr_block, dlen, '0));
                        step_actions.push_back(act_word(ACT_ACK, tr_block, '0, '0));
                        if (dlen < BLK_SZ)
                        begin
                            tr_phase = PH_IDLE;
                            step_actions.push_back(act_word(ACT_DONE, '0, '0, '0));
                        end
                        else
                            tr_block = tr_block + BLK_W'(1);
                    end
                end
                else if (tr_phase == PH_WAIT_ACK)
                begin
                    if (rlen >= HDR_LEN && ev.rx_opcode == OPC_ACK && ev.rx_block == tr_block)
                    begin
                        if (tr_len < BLK_SZ)
                        begin
                            tr_phase = PH_IDLE;
                            step_actions.push_back(act_word(ACT_DONE, '0, '0, '0));
                        end
                        else
                        begin
                            tr_block = tr_block + BLK_W'(1);
                            tr_phase = PH_FETCH;
                            step_actions.push_back(act_word(ACT_FETCH, tr_block, '0, '0));
                        end
                    end
                    else
                        resend_block();
                end
            end
        endcase
        if (step_actions.size() != 0)
        begin
            tail = step_actions.pop_back();
            tail.last = 1'b1;
            step_actions.push_back(tail);
        end
    endfunction

    function automatic event_t pick_event();
        event_t ev;
        int     roll;
        int     pick;
        roll = $urandom_range(99);
        pick = $urandom_range(9);
        ev.func         = FN_RX;
        ev.rx_opcode    = OPC_W'($urandom);
        ev.rx_block     = BLK_W'($urandom);
        ev.rx_length    = LEN_W'($urandom);
        ev.local_length = LEN_W'($urandom);
        if (roll < 15)
            ev.func = FUNC_W'($urandom);
        else
        begin
            case (tr_phase)
                PH_IDLE:
                    ev.func = FN_START;
                PH_REQ_GET, PH_RECV:
                begin
                    if (roll < 22)
                        ev.func = FN_TIMEOUT;
                    else if (roll < 26)
                        ev.rx_opcode = OPC_ERROR;
                    else if (roll < 29)
                        ev.rx_length = LEN_W'($urandom_range(3));
                    else if (roll < 32)
                    begin
                        ev.rx_opcode = OPC_DATA;
                        ev.rx_block  = tr_block - BLK_W'(1);
                    end
                    else
                    begin
                        ev.rx_opcode = OPC_DATA;
                        ev.rx_block  = tr_block;
                        ev.rx_length = (pick < 6) ? LEN_W'(BLOCK_SIZE + 4) :
                                       (pick < 8) ? LEN_W'($urandom_range(4, BLOCK_SIZE + 3)) :
                                       LEN_W'($urandom_range(BLOCK_SIZE + 5, 1023));
                    end
                end
                PH_REQ_PUT:
                begin
                    if (roll < 35)
                        ev.func = FN_TIMEOUT;
                    else if (roll < 39)
                        ev.rx_opcode = OPC_ERROR;
                    else if (roll < 45)
                        ev.rx_opcode = OPC_ACK;
                    else
                    begin
                        ev.rx_opcode = OPC_ACK;
                        ev.rx_block  = '0;
                        ev.rx_length = LEN_W'($urandom_range(4, 1023));
                    end
                end
                PH_FETCH:
                begin
                    if (roll >= 25)
                    begin
                        ev.func = FN_LOCAL;
                        ev.local_length = (pick < 6) ? BLK_SZ :
                                          (pick < 8) ? LEN_W'($urandom_range(BLOCK_SIZE - 1)) :
                                          LEN_W'($urandom_range(BLOCK_SIZE + 1, 1023));
                    end
                end
                PH_WAIT_ACK:
                begin
                    if (roll < 22)
                        ev.func = FN_TIMEOUT;
                    else if (roll < 30)
                        ev.rx_opcode = OPC_ACK;
                    else
                    begin
                        ev.rx_opcode = OPC_ACK;
                        ev.rx_block  = tr_block;
                        ev.rx_length = LEN_W'($urandom_range(4, 1023));
                    end
                end
                default:
                    ev.func = FN_START;
            endcase
        end
        return ev;
    endfunction

    function automatic plan_row_t ev_row(func_t f, logic [OPC_W-1:0] opc, logic [BLK_W-1:0] blk,
                                         logic [LEN_W-1:0] rlen, logic [LEN_W-1:0] llen);
        plan_row_t row;
        row = '0;
        row.ev = {f, opc, blk, rlen, llen};
        return row;
    endfunction

    function automatic plan_row_t typed_row(plan_row_t row, action_t a, logic [BLK_W-1:0] b,
                                            logic [LEN_W-1:0] l, logic [BLK_W-1:0] e);
        row.typed     = 1'b1;
        row.want      = act_word(a, b, l, e);
        row.want.last = 1'b1;
        return row;
    endfunction

    function automatic plan_row_t reg_row(reg_idx_t idx, logic [CFG_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.reg_write = 1'b1;
        row.reg_sel   = idx;
        row.reg_val   = val;
        return row;
    endfunction

    task automatic send_event(input event_t ev, input logic typed, input result_t want);
        while ($urandom_range(99) < snd_idle)
        begin
            evt_bus.valid <= 1'b0;
            @(negedge clk);
        end
        evt_bus.valid        <= 1'b1;
        evt_bus.func         <= ev.func;
        evt_bus.rx_opcode    <= ev.rx_opcode;
        evt_bus.rx_block     <= ev.rx_block;
        evt_bus.rx_length    <= ev.rx_length;
        evt_bus.local_length <= ev.local_length;
        @(posedge clk);
        while (!evt_bus.ready)
            @(posedge clk);
        advance_transfer(ev);
        if (typed)
            actions_due.push_back(want);
        else
            foreach (step_actions[i])
                actions_due.push_back(step_actions[i]);
        n_events++;
        if (step_actions.size() != 0)
            n_active++;
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        if (idx == REG_DIRECTION)
            reg_dir = val[0];
        else
            reg_tries = val;
        n_writes++;
        @(negedge clk);
    endtask

    // hold events until every action has come out and the pipe is empty
    task automatic settle();
        evt_bus.valid <= 1'b0;
        while (actions_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
        act_bus.ready <= rst_n && ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin : action_check
        result_t got;
        result_t want;
        if (rst_n && act_bus.valid && act_bus.ready)
        begin
            got = {act_bus.action, act_bus.block_number, act_bus.payload_length,
                   act_bus.error_code, act_bus.last};
            if (actions_due.size() == 0)
                flag_error($sformatf("unexpected action word: act=%0d blk=%0d len=%0d err=%0d last=%0d",
                                     got.action, got.block_number, got.payload_length,
                                     got.error_code, got.last));
            else
            begin
                want = actions_due.pop_front();
                n_checked++;
                if (got.action !== want.action || got.block_number !== want.block_number ||
                    got.payload_length !== want.payload_length ||
                    got.error_code !== want.error_code || got.last !== want.last)
                    flag_error($sformatf({"action word %0d: expected act=%0d blk=%0d len=%0d ",
                                          "err=%0d last=%0d, got act=%0d blk=%0d len=%0d ",
                                          "err=%0d last=%0d"},
                                         n_checked, want.action, want.block_number,
                                         want.payload_length, want.error_code, want.last,
                                         got.action, got.block_number, got.payload_length,
                                         got.error_code, got.last));
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t plan [$];
        event_t    ev;
        int        got;

        rst_n                = 1'b0;
        evt_bus.valid        = 1'b0;
        evt_bus.func         = FN_START;
        evt_bus.rx_opcode    = '0;
        evt_bus.rx_block     = '0;
        evt_bus.rx_length    = '0;
        evt_bus.local_length = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_DIRECTION;
        cfg_bus.data         = '0;

        tr_phase  = PH_IDLE;
        tr_block  = BLK_W'(1);
        tr_tries  = '0;
        tr_len    = '0;
        reg_dir   = 1'b0;
        reg_tries = ATT_RESET;

        // get with reset settings
        plan.push_back(ev_row(FN_TIMEOUT, 8'd0, 16'd0, 10'd0, 10'd0));
        plan.push_back(typed_row(ev_row(FN_START, 8'hff, 16'hffff, 10'h3ff, 10'h3ff),
                                 ACT_REQ, '0, '0, '0));
        plan.push_back(typed_row(ev_row(FN_RX, OPC_DATA, 16'd1, 10'd3, 10'd0),
                                 ACT_TFAIL, '0, '0, '0));
        plan.push_back(typed_row(ev_row(FN_START, 8'd0, 16'd0, 10'd0, 10'd0),
                                 ACT_REQ, '0, '0, '0));
        plan.push_back(typed_row(ev_row(FN_RX, OPC_ERROR, 16'hffff, 10'd4, 10'd0),
                                 ACT_SERR, '0, '0, 16'hffff));
        plan.push_back(ev_row(FN_START, 8'd0, 16'd0, 10'd0, 10'd0));
        plan.push_back(ev_row(FN_START, 8'd0, 16'd0, 10'd0, 10'd0));
        plan.push_back(ev_row(FN_TIMEOUT, 8'd0, 16'd0, 10'd0, 10'd0));
        plan.push_back(ev_row(FN_RX, OPC_DATA, 16'd1, 10'd516, 10'd0));
        plan.push_back(ev_row(FN_RX, OPC_DATA, 16'd1, 10'd516, 10'd0));
        plan.push_back(ev_row(FN_RX, OPC_ERROR, 16'd2, 10'd4, 10'd0));
        plan.push_back(ev_row(FN_RX, OPC_DATA, 16'd2, 10'd3, 10'd0));
        plan.push_back(ev_row(FN_RX, OPC_DATA, 16'd2, 10'h3ff, 10'd0));
        plan.push_back(ev_row(FN_RX, OPC_DATA, 16'd3, 10'd4, 10'd0));
        plan.push_back(ev_row(FN_LOCAL, 8'd0, 16'd0, 10'd0, 10'h3ff));
        // put with a zero attempt limit
        plan.push_back(reg_row(REG_DIRECTION, 4'd1));
        plan.push_back(reg_row(REG_MAX_ATTEMPTS, 4'd0));
        plan.push_back(ev_row(FN_START, 8'd0, 16'd0, 10'd0, 10'd0));
        plan.push_back(ev_row(FN_RX, 8'hff, 16'd0, 10'd4, 10'd0));
        plan.push_back(typed_row(ev_row(FN_RX, OPC_ACK, 16'd0, 10'd4, 10'd0),
                                 ACT_FETCH, 16'd1, '0, '0));
        plan.push_back(typed_row(ev_row(FN_LOCAL, 8'd0, 16'd0, 10'd0, 10'h3ff),
                                 ACT_DATA, 16'd1, 10'd512, '0));
        plan.push_back(typed_row(ev_row(FN_RX, OPC_ACK, 16'd0, 10'd4, 10'd0),
                                 ACT_TFAIL, '0, '0, '0));
        plan.push_back(ev_row(FN_START, 8'd0, 16'd0, 10'd0, 10'd0));
        plan.push_back(typed_row(ev_row(FN_TIMEOUT, 8'd0, 16'd0, 10'd0, 10'd0),
                                 ACT_TFAIL, '0, '0, '0));
        plan.push_back(ev_row(FN_START, 8'd0, 16'd0, 10'd0, 10'd0));
        plan.push_back(ev_row(FN_RX, OPC_ACK, 16'd0, 10'd4, 10'd0));
        plan.push_back(ev_row(FN_LOCAL, 8'd0, 16'd0, 10'd0, 10'd100));
        plan.push_back(ev_row(FN_RX, OPC_ACK, 16'd1, 10'd4, 10'd0));

        snd_idle = 11;
        rcv_idle = 51;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].reg_write)
            begin
                settle();
                write_reg(plan[i].reg_sel, plan[i].reg_val);
                cfg_bus.valid <= 1'b0;
            end
            else
                send_event(plan[i].ev, plan[i].typed, plan[i].want);
        end

        for (int seg = 0; seg < RAND_SEGMENTS; seg++)
        begin
            settle();
            write_reg(REG_DIRECTION, {CFG_W'($urandom_range(7)) << 1} | CFG_W'(seg % 2));
            write_reg(REG_MAX_ATTEMPTS, (seg == 0 || seg == 3) ? CFG_W'(1) :
                                        (seg < 3) ? CFG_W'(15) : CFG_W'($urandom_range(15)));
            cfg_bus.valid <= 1'b0;
            snd_idle = (seg < 2) ? 11 : (seg < 4) ? 51 : 0;
            rcv_idle = (seg < 2) ? 51 : (seg < 4) ? 11 : 0;
            got = 0;
            while (got < SEG_ACTIVE)
            begin
                if ($urandom_range(29) == 0)
                    settle();
                ev = pick_event();
                send_event(ev, 1'b0, '0);
                if (step_actions.size() != 0)
                    got++;
            end
        end

        settle();
        if (actions_due.size() != 0)
            flag_error($sformatf("%0d action words never arrived", actions_due.size()));
        $display("%0d events in get and put transfers, %0d of them drew actions",
                 n_events, n_active);
        $display("%0d action words checked across %0d register writes, %0d failures",
                 n_checked, n_writes, err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* tftp_transfer_engine.f */
hw/rtl/tte_pkg.sv
hw/rtl/tte_if.sv
hw/rtl/tte_step.sv
hw/rtl/tte_out_fifo.sv
hw/rtl/tftp_transfer_engine.sv
tb/tftp_transfer_engine_tb.sv
